// File: hdl/atsb_pkg.sv
// shared types and constants for the affine texture span blend unit
// no dependencies
`timescale 1ns / 1ps
package atsb_pkg;

	// texture memory size in bytes
	localparam int TEX_BYTES = 65536;

	typedef enum logic [2:0] {
		REQ_TEX_LOAD   = 3'd0,
		REQ_BLEND_LOAD = 3'd1,
		REQ_BLEND_PRES = 3'd2,
		REQ_PAL_LOAD   = 3'd3,
		REQ_SPAN       = 3'd4,
		REQ_PIXEL      = 3'd5,
		REQ_RSVD6      = 3'd6,
		REQ_RSVD7      = 3'd7
	} req_t;

	localparam logic [2:0] CFG_TRANSPARENT = 3'd0;
	localparam logic [2:0] CFG_POW2        = 3'd1;
	localparam logic [2:0] CFG_PALETTE     = 3'd2;
	localparam logic [2:0] CFG_WIDTH_LOG2  = 3'd3;
	localparam logic [2:0] CFG_ADDR_MASK   = 3'd4;
	localparam logic [2:0] CFG_ROW_BYTES   = 3'd5;

	// classified word handed from front to back
	typedef struct packed {
		req_t        req;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [7:0]  dest;
		logic        reject;
		logic [15:0] pixels;
		logic [31:0] u_step;
		logic [31:0] v_step;
		logic [31:0] left_u;
		logic [31:0] left_v;
	} cmd_t;

	// result word
	typedef struct packed {
		logic [7:0]  pixel;
		logic        we;
		logic        reject;
		logic [15:0] pixels;
	} res_t;

endpackage

// File: hdl/atsb_div.sv
// iterative signed divider for 16.16 span steps, one quotient bit per cycle
// depends on atsb_pkg
`timescale 1ns / 1ps
module atsb_div
	import atsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] delta,
	input  logic [32:0] dx,
	output logic        done,
	output logic [31:0] quot
);
	// |delta|*65536 < 2^49, quotient up to 49 bits
	localparam int NB = 49;

	logic [NB-1:0] num_q;
	logic [NB-1:0] q_q;
	logic [33:0]   rem_q;
	logic [32:0]   den_q;
	logic          neg_q;
	logic          busy_q;
	logic [5:0]    cnt_q;
	logic [33:0]   trial;
	logic [NB:0]   sq;

	assign trial = {rem_q[32:0], num_q[NB-1]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(NB);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	// restoring division datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= {(delta[32] ? 33'(-delta) : delta), 16'd0};
			den_q <= dx;
			rem_q <= '0;
			q_q   <= '0;
			neg_q <= delta[32];
		end else if (busy_q) begin
			num_q <= {num_q[NB-2:0], 1'b0};
			if (!trial[33]) begin
				rem_q <= trial;
				q_q   <= {q_q[NB-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], num_q[NB-1]};
				q_q   <= {q_q[NB-2:0], 1'b0};
			end
		end
	end

	// sign and saturate
	always_comb begin
		sq = neg_q ? (NB+1)'(-{1'b0, q_q}) : {1'b0, q_q};
		if (!neg_q && q_q > NB'(32'h7fff_ffff))
			quot = 32'h7fff_ffff;
		else if (neg_q && q_q > NB'(33'h8000_0000))
			quot = 32'h8000_0000;
		else
			quot = sq[31:0];
	end
endmodule

// File: hdl/atsb_front.sv
// front end: accepts words, computes span setup, pushes commands
// depends on atsb_pkg, atsb_div
`timescale 1ns / 1ps
module atsb_front
	import atsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	input  logic [31:0] left_u,
	input  logic [31:0] right_u,
	input  logic [31:0] left_v,
	input  logic [31:0] right_v,
	input  logic [31:0] left_x,
	input  logic [31:0] right_x,
	input  logic [7:0]  dest_pixel,
	output logic        push,
	output cmd_t        push_cmd,
	input  logic        q_full
);
	typedef enum logic [1:0] {ST_IDLE, ST_DIVU, ST_DIVV, ST_PUSH} st_t;

	st_t         st_q;
	cmd_t        cmd_q;
	logic [32:0] du_q, dv_q, dx_q;
	logic        div_start, div_done;
	logic [32:0] div_delta;
	logic [31:0] quot;
	logic        acc;
	logic [32:0] dx;
	logic [33:0] cl, cr;
	logic [17:0] fl, fr;
	logic [18:0] cnt;
	cmd_t        dcmd;

	assign in_stall = (st_q != ST_IDLE) || q_full;
	assign acc      = in_valid && !in_stall;
	assign dx       = {right_x[31], right_x} - {left_x[31], left_x};

	// ceil counts
	always_comb begin
		cl  = {{2{left_x[31]}}, left_x} + 34'd65535;
		cr  = {{2{right_x[31]}}, right_x} + 34'd65535;
		fl  = cl[33:16];
		fr  = cr[33:16];
		cnt = {fr[17], fr} - {fl[17], fl};
		dcmd        = '0;
		dcmd.req    = req_t'(req_type);
		dcmd.addr   = addr;
		dcmd.data   = data;
		dcmd.dest   = dest_pixel;
		dcmd.left_u = left_u;
		dcmd.left_v = left_v;
		dcmd.reject = dx[32] || (dx == '0);
		if (cnt[18])
			dcmd.pixels = '0;
		else if (cnt[17:16] != 2'd0)
			dcmd.pixels = 16'hffff;
		else
			dcmd.pixels = cnt[15:0];
	end

	assign div_start = (acc && req_t'(req_type) == REQ_SPAN && !dcmd.reject) ||
		(st_q == ST_DIVU && div_done);
	assign div_delta = (st_q == ST_DIVU) ? dv_q :
		({right_u[31], right_u} - {left_u[31], left_u});

	atsb_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.delta(div_delta), .dx((st_q == ST_DIVU) ? dx_q : dx),
		.done(div_done), .quot(quot)
	);

	// span sequencer and push
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			push <= 1'b0;
		end else begin
			push <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (acc) begin
						if (req_t'(req_type) == REQ_SPAN && !dcmd.reject)
							st_q <= ST_DIVU;
						else if (req_type != REQ_RSVD6 && req_type != REQ_RSVD7)
							push <= 1'b1;
					end
				end
				ST_DIVU: if (div_done) st_q <= ST_DIVV;
				ST_DIVV: if (div_done) st_q <= ST_PUSH;
				ST_PUSH: begin
					push <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_q <= dcmd;
			dx_q  <= dx;
			dv_q  <= {right_v[31], right_v} - {left_v[31], left_v};
		end
		if (st_q == ST_DIVU && div_done) cmd_q.u_step <= quot;
		if (st_q == ST_DIVV && div_done) cmd_q.v_step <= quot;
	end

	assign push_cmd = cmd_q;
endmodule

// File: hdl/atsb_fifo.sv
// short command queue between front and back
// depends on atsb_pkg
`timescale 1ns / 1ps
module atsb_fifo
	import atsb_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);
	cmd_t       mem_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] n_q;

	assign full  = n_q >= 3'd2; // leaves room for the in-flight push
	assign empty = n_q == 3'd0;
	assign head  = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			n_q  <= '0;
		end else begin
			if (push) wp_q <= wp_q + 2'd1;
			if (pop)  rp_q <= rp_q + 2'd1;
			n_q <= n_q + {2'd0, push} - {2'd0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= push_cmd;
	end
endmodule

// File: hdl/atsb_back.sv
// back end: memories, texel fetch, blend and palette, result register
// depends on atsb_pkg
`timescale 1ns / 1ps
module atsb_back
	import atsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  cmd_t        head,
	output logic        pop,
	input  logic        cfg_transparent,
	input  logic        cfg_pow2,
	input  logic        cfg_palette,
	input  logic [3:0]  cfg_wlog2,
	input  logic [15:0] cfg_mask,
	input  logic [15:0] cfg_row,
	output logic        out_valid,
	input  logic        out_stall,
	output res_t        res
);
	localparam int TAW = $clog2(TEX_BYTES);

	typedef enum logic [2:0] {ST_IDLE, ST_TEX, ST_BLEND, ST_PAL, ST_FIN, ST_OUT} st_t;

	logic [7:0]  tex_mem   [TEX_BYTES];
	logic [7:0]  blend_mem [65536];
	logic [7:0]  pal_mem   [256];
	logic [255:0] pres_q;

	st_t         st_q;
	logic [31:0] u_q, v_q, us_q, vs_q;
	logic [7:0]  dest_q, rd_q, val_q;
	logic [TAW-1:0] k_q;
	logic [31:0] k;
	logic [15:0] fu, fv;
	logic        go;
	logic        hit_q;
	logic [7:0]  pix_q;
	logic        we_q, rej_q;
	logic [15:0] npix_q;
	logic [7:0]  sel;
	logic        res_load;

	assign fu = u_q[31:16];
	assign fv = v_q[31:16];
	assign go = !q_empty && st_q == ST_IDLE;
	assign pop = go;

	// blended or raw texel, and result register free to load
	assign sel      = hit_q ? rd_q : val_q;
	assign res_load = (st_q == ST_OUT) && (!out_valid || !out_stall);

	// texel address, wraps to 32 bits
	always_comb begin
		if (cfg_pow2)
			k = (({{16{fv[15]}}, fv} << cfg_wlog2) + {{16{fu[15]}}, fu}) &
				{16'd0, cfg_mask};
		else
			k = {{16{fv[15]}}, fv} * {16'd0, cfg_row} + {{16{fu[15]}}, fu};
	end

	// memory writes
	always_ff @(posedge clk) begin
		if (go && head.req == REQ_TEX_LOAD)   tex_mem[head.addr[TAW-1:0]] <= head.data;
		if (go && head.req == REQ_BLEND_LOAD) blend_mem[head.addr] <= head.data;
		if (go && head.req == REQ_PAL_LOAD)   pal_mem[head.addr[7:0]] <= head.data;
	end

	// memory reads, one per step
	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_TEX:   rd_q <= tex_mem[k_q];
			ST_BLEND: rd_q <= blend_mem[{rd_q, dest_q}];
			ST_PAL:   rd_q <= pal_mem[sel];
			default:  rd_q <= rd_q;
		endcase
	end

	// pixel sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			out_valid <= 1'b0;
			pres_q    <= '0;
			u_q <= '0; v_q <= '0; us_q <= '0; vs_q <= '0;
			res <= '0;
			dest_q <= '0; val_q <= '0; k_q <= '0;
			hit_q <= 1'b0; pix_q <= '0; we_q <= 1'b0; rej_q <= 1'b0; npix_q <= '0;
		end else begin
			if (res_load)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (go) begin
					unique case (head.req)
						REQ_BLEND_PRES: pres_q[head.addr[7:0]] <= head.data[0];
						REQ_SPAN: begin
							if (!head.reject) begin
								us_q <= head.u_step; vs_q <= head.v_step;
								u_q <= head.left_u;  v_q <= head.left_v;
							end
							pix_q  <= 8'd0;
							we_q   <= 1'b0;
							rej_q  <= head.reject;
							npix_q <= head.reject ? 16'd0 : head.pixels;
							st_q   <= ST_OUT;
						end
						REQ_PIXEL: begin
							k_q    <= k[TAW-1:0];
							dest_q <= head.dest;
							u_q <= u_q + us_q;
							v_q <= v_q + vs_q;
							st_q <= ST_TEX;
						end
						default: ;
					endcase
				end
				ST_TEX: st_q <= ST_BLEND;
				ST_BLEND: begin
					// rd_q holds the texel, blend table read issued now
					val_q <= rd_q;
					hit_q <= pres_q[rd_q];
					if (cfg_transparent && rd_q == 8'd0) begin
						pix_q  <= dest_q;
						we_q   <= 1'b0;
						rej_q  <= 1'b0;
						npix_q <= 16'd0;
						st_q   <= ST_OUT;
					end else begin
						st_q <= ST_PAL;
					end
				end
				ST_PAL: begin
					// palette read of the selected value issued now
					if (cfg_palette) begin
						st_q <= ST_FIN;
					end else begin
						pix_q  <= sel;
						we_q   <= 1'b1;
						rej_q  <= 1'b0;
						npix_q <= 16'd0;
						st_q   <= ST_OUT;
					end
				end
				ST_FIN: begin
					pix_q  <= rd_q;
					we_q   <= 1'b1;
					rej_q  <= 1'b0;
					npix_q <= 16'd0;
					st_q   <= ST_OUT;
				end
				ST_OUT: begin
					if (res_load) begin
						res  <= '{pixel: pix_q, we: we_q, reject: rej_q, pixels: npix_q};
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hdl/affine_texture_span_blend_unit.sv
// Affine texture span blend unit, top level.
// Input channel: in_valid/in_stall with req_type, addr, data, edges and dest_pixel.
// Output channel: out_valid/out_stall with pixel_out, write_enable,
// span_reject and span_pixels. Loads and unused requests give no word.
// Config: cfg_we/cfg_index/cfg_data, which must be written only while idle;
// the block itself does not enforce this. A span word runs two 49-step serial
// divisions in the front end, stalling the input until its command is pushed.
// A rejected span and other words are registered and pushed with no stall;
// reserved words are dropped. A pixel word walks the back end through memory
// reads (texture, blend table, palette): ST_TEX, ST_BLEND, ST_PAL, ST_FIN;
// without palette ST_FIN is skipped, and a transparent texel goes to ST_OUT
// from ST_BLEND. Loads finish in ST_IDLE; a span goes straight to ST_OUT.
// A four-entry queue decouples front and back; in_stall rises at two entries.
// Reset clears control, accumulators, steps and blend present flags;
// memories hold nothing defined until loaded.
// When out_stall is high the result holds, the back end finishes the next
// word into its work registers and waits.
`timescale 1ns / 1ps
module affine_texture_span_blend_unit
	import atsb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [15:0] addr,
	input  logic [7:0]  data,
	input  logic [31:0] left_u,
	input  logic [31:0] right_u,
	input  logic [31:0] left_v,
	input  logic [31:0] right_v,
	input  logic [31:0] left_x,
	input  logic [31:0] right_x,
	input  logic [7:0]  dest_pixel,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  pixel_out,
	output logic        write_enable,
	output logic        span_reject,
	output logic [15:0] span_pixels,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	logic        push, full, pop, empty;
	cmd_t        push_cmd, head;
	res_t        res;
	logic        tr_q, p2_q, pal_q;
	logic [3:0]  wl_q;
	logic [15:0] mask_q, row_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tr_q <= 1'b0; p2_q <= 1'b1; pal_q <= 1'b0;
			wl_q <= 4'd6; mask_q <= 16'd4095; row_q <= 16'd64;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TRANSPARENT: tr_q   <= cfg_data[0];
				CFG_POW2:        p2_q   <= cfg_data[0];
				CFG_PALETTE:     pal_q  <= cfg_data[0];
				CFG_WIDTH_LOG2:  wl_q   <= cfg_data[3:0];
				CFG_ADDR_MASK:   mask_q <= cfg_data;
				CFG_ROW_BYTES:   row_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	atsb_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .req_type, .addr, .data,
		.left_u, .right_u, .left_v, .right_v, .left_x, .right_x, .dest_pixel,
		.push, .push_cmd, .q_full(full)
	);

	atsb_fifo u_fifo (
		.clk, .arst_n, .push, .push_cmd, .full, .pop, .empty, .head
	);

	atsb_back u_back (
		.clk, .arst_n, .q_empty(empty), .head, .pop,
		.cfg_transparent(tr_q), .cfg_pow2(p2_q), .cfg_palette(pal_q),
		.cfg_wlog2(wl_q), .cfg_mask(mask_q), .cfg_row(row_q),
		.out_valid, .out_stall, .res
	);

	assign pixel_out    = res.pixel;
	assign write_enable = res.we;
	assign span_reject  = res.reject;
	assign span_pixels  = res.pixels;
endmodule

// File: hdl/atsb_checker.sv
// port-level checker for the affine texture span blend unit
// depends on atsb_pkg; bound to the top level
`timescale 1ns / 1ps
module atsb_checker
	import atsb_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic        write_enable,
	input logic        span_reject,
	input logic [15:0] span_pixels,
	input logic [7:0]  pixel_out
);
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(span_pixels) && $stable(pixel_out))
		else $error("stalled result changed");

	// a rejected span reports no pixels
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && span_reject |-> span_pixels == 16'd0 && !write_enable)
		else $error("rejected span with pixels");

	// a write never comes with span fields
	a_we: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> !span_reject && span_pixels == 16'd0)
		else $error("pixel word carries span fields");
endmodule

bind affine_texture_span_blend_unit atsb_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .write_enable,
	.span_reject, .span_pixels, .pixel_out
);

// File: bench/tb_affine_texture_span_blend_unit.sv
// self-checking testbench for the affine texture span blend unit
// depends on atsb_pkg and affine_texture_span_blend_unit; predicts every result word in-line
`timescale 1ns / 1ps
module tb_affine_texture_span_blend_unit;
	import atsb_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 250;

	typedef struct {
		req_t        req;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [31:0] lu, ru, lv, rv, lx, rx;
		logic [7:0]  dest;
	} word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [2:0] req_type = '0;
	logic [15:0] addr = '0;
	logic [7:0] data = '0;
	logic [31:0] left_u = '0, right_u = '0, left_v = '0, right_v = '0;
	logic [31:0] left_x = '0, right_x = '0;
	logic [7:0] dest_pixel = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] pixel_out;
	logic write_enable, span_reject;
	logic [15:0] span_pixels;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	affine_texture_span_blend_unit u_dut (.*);

	always #5 clk = ~clk;

	// predicted block state
	logic [7:0] tex_img [65536];
	bit tex_known [65536];
	logic [7:0] blend_tab [65536];
	bit blend_known [65536];
	bit blend_flag [256];
	logic [7:0] pal_tab [256];
	bit pal_known [256];
	logic [31:0] u_acc, v_acc, u_inc, v_inc;
	bit m_transp, m_pow2, m_pal;
	logic [3:0] w_log2;
	logic [15:0] a_mask, row_bytes;

	word_t pending_words [$];
	res_t expected_results [$];
	int errors, n_span, n_pixel, n_load, n_rsvd, n_checked;
	bit quiet, hold_sender;
	int idle_in, idle_out, stale_cycles;

	function automatic logic [31:0] span_step(longint d, longint dx);
		longint q;
		q = (d * 65536) / dx;
		if (q > 64'sd2147483647) q = 64'sd2147483647;
		if (q < -64'sd2147483648) q = -64'sd2147483648;
		return q[31:0];
	endfunction

	function automatic logic [15:0] texel_index();
		logic [31:0] fu, fv, k;
		fu = {{16{u_acc[31]}}, u_acc[31:16]};
		fv = {{16{v_acc[31]}}, v_acc[31:16]};
		if (m_pow2) k = ((fv << w_log2) + fu) & {16'd0, a_mask};
		else k = fv * {16'd0, row_bytes} + fu;
		return k[15:0];
	endfunction

	// apply one word to the predicted state and queue it for the driver
	task automatic issue(word_t w);
		res_t r;
		longint lx, rx, dx, cnt;
		logic [7:0] tx, val;
		r = '0;
		case (w.req)
			REQ_TEX_LOAD: begin
				tex_img[w.addr] = w.data; tex_known[w.addr] = 1; n_load++;
			end
			REQ_BLEND_LOAD: begin
				blend_tab[w.addr] = w.data; blend_known[w.addr] = 1; n_load++;
			end
			REQ_BLEND_PRES: begin
				blend_flag[w.addr[7:0]] = w.data[0]; n_load++;
			end
			REQ_PAL_LOAD: begin
				pal_tab[w.addr[7:0]] = w.data; pal_known[w.addr[7:0]] = 1; n_load++;
			end
			REQ_SPAN: begin
				lx = longint'($signed(w.lx));
				rx = longint'($signed(w.rx));
				dx = rx - lx;
				if (dx <= 0) begin
					r.reject = 1'b1;
				end else begin
					u_inc = span_step(longint'($signed(w.ru)) - longint'($signed(w.lu)), dx);
					v_inc = span_step(longint'($signed(w.rv)) - longint'($signed(w.lv)), dx);
					u_acc = w.lu;
					v_acc = w.lv;
					cnt = ((rx + 65535) >>> 16) - ((lx + 65535) >>> 16);
					if (cnt < 0) cnt = 0;
					if (cnt > 65535) cnt = 65535;
					r.pixels = cnt[15:0];
				end
				expected_results.push_back(r); n_span++;
			end
			REQ_PIXEL: begin
				tx = tex_img[texel_index()];
				if (m_transp && tx == 8'd0) begin
					r.pixel = w.dest;
				end else begin
					val = blend_flag[tx] ? blend_tab[{tx, w.dest}] : tx;
					if (m_pal) val = pal_tab[val];
					r.pixel = val;
					r.we = 1'b1;
				end
				u_acc += u_inc;
				v_acc += v_inc;
				expected_results.push_back(r); n_pixel++;
			end
			default: n_rsvd++;
		endcase
		pending_words.push_back(w);
	endtask

	function automatic word_t blank_word(req_t rq);
		word_t w;
		w.req = rq;
		w.addr = 16'($urandom); w.data = 8'($urandom); w.dest = 8'($urandom);
		w.lu = $urandom; w.ru = $urandom; w.lv = $urandom;
		w.rv = $urandom; w.lx = $urandom; w.rx = $urandom;
		return w;
	endfunction

	task automatic load(req_t rq, logic [15:0] a, logic [7:0] d);
		word_t w;
		w = blank_word(rq);
		w.addr = a; w.data = d;
		issue(w);
	endtask

	// pixel word, preceded by whatever loads keep every memory read it uses defined
	task automatic pixel(logic [7:0] dst);
		word_t w;
		logic [15:0] k;
		logic [7:0] tx, val;
		k = texel_index();
		if (!tex_known[k])
			load(REQ_TEX_LOAD, k, ($urandom_range(0, 5) == 0) ? 8'd0 : 8'($urandom));
		tx = tex_img[k];
		if (!(m_transp && tx == 8'd0)) begin
			if (blend_flag[tx] && !blend_known[{tx, dst}])
				load(REQ_BLEND_LOAD, {tx, dst}, 8'($urandom));
			val = blend_flag[tx] ? blend_tab[{tx, dst}] : tx;
			if (m_pal && !pal_known[val]) load(REQ_PAL_LOAD, {8'd0, val}, 8'($urandom));
		end
		w = blank_word(REQ_PIXEL);
		w.dest = dst;
		issue(w);
	endtask

	task automatic span(logic [31:0] lu, ru, lv, rv, lx, rx);
		word_t w;
		w = blank_word(REQ_SPAN);
		w.lu = lu; w.ru = ru; w.lv = lv; w.rv = rv; w.lx = lx; w.rx = rx;
		issue(w);
	endtask

	// random span; mostly a small texture window, sometimes full-range edges
	task automatic random_span();
		logic [31:0] e [6];
		foreach (e[i]) e[i] = $urandom;
		if ($urandom_range(0, 4) != 0) begin
			e[0] = $signed($urandom_range(0, 6000000)) - 1000000;
			e[1] = $signed($urandom_range(0, 6000000)) - 1000000;
			e[2] = $signed($urandom_range(0, 6000000)) - 1000000;
			e[3] = $signed($urandom_range(0, 6000000)) - 1000000;
			e[4] = $signed($urandom_range(0, 4000000)) - 500000;
			e[5] = ($urandom_range(0, 7) == 0) ? e[4] - $urandom_range(0, 70000)
				: e[4] + $urandom_range(1, 3000000);
		end
		span(e[0], e[1], e[2], e[3], e[4], e[5]);
	endtask

	// issues about n_words words, the loads that pixels need included
	task automatic random_phase(int n_words);
		int base, k;
		base = n_span + n_pixel + n_load + n_rsvd;
		while (n_span + n_pixel + n_load + n_rsvd - base < n_words) begin
			case ($urandom_range(0, 9))
				0: begin
					load(REQ_TEX_LOAD, 16'($urandom), 8'($urandom));
				end
				1: begin
					load(REQ_BLEND_PRES, 16'($urandom), 8'($urandom));
				end
				2: begin
					load(REQ_BLEND_LOAD, 16'($urandom), 8'($urandom));
					load(REQ_PAL_LOAD, 16'($urandom), 8'($urandom));
				end
				3: begin
					issue(blank_word($urandom_range(0, 1) ? REQ_RSVD6 : REQ_RSVD7));
					pixel(8'($urandom));
				end
				default: begin
					random_span();
					k = $urandom_range(1, 10);
					repeat (k) pixel(8'($urandom));
				end
			endcase
		end
	endtask

	// wait until the block has nothing left to do
	task automatic drain();
		while (pending_words.size() != 0 || expected_results.size() != 0 || in_valid)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			CFG_TRANSPARENT: m_transp = val[0];
			CFG_POW2:        m_pow2 = val[0];
			CFG_PALETTE:     m_pal = val[0];
			CFG_WIDTH_LOG2:  w_log2 = val[3:0];
			CFG_ADDR_MASK:   a_mask = val;
			CFG_ROW_BYTES:   row_bytes = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_modes(bit tr, bit p2, bit pl, logic [3:0] wl, logic [15:0] mk,
		logic [15:0] rb);
		write_reg(CFG_TRANSPARENT, {15'($urandom), tr});
		write_reg(CFG_POW2, {15'($urandom), p2});
		write_reg(CFG_PALETTE, {15'($urandom), pl});
		write_reg(CFG_WIDTH_LOG2, {12'($urandom), wl});
		write_reg(CFG_ADDR_MASK, mk);
		write_reg(CFG_ROW_BYTES, rb);
		write_reg(3'd6 + 3'($urandom_range(0, 1)), 16'($urandom));
	endtask

	// stimulus
	initial begin
		m_transp = 0; m_pow2 = 1; m_pal = 0;
		w_log2 = 4'd6; a_mask = 16'd4095; row_bytes = 16'd64;
		u_acc = '0; v_acc = '0; u_inc = '0; v_inc = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: loads, reject cases, clamps, step overflow, reserved codes
		load(REQ_TEX_LOAD, 16'd0, 8'd0);
		load(REQ_TEX_LOAD, 16'hFFFF, 8'hFF);
		load(REQ_BLEND_PRES, 16'hFF07, 8'h01);
		load(REQ_BLEND_LOAD, 16'h0733, 8'hA5);
		load(REQ_PAL_LOAD, 16'h00FF, 8'h5A);
		pixel(8'h00);
		span(32'h0000_0000, 32'h0000_0000, 32'h0, 32'h0, 32'h0001_0000, 32'h0001_0000);
		span(32'h0, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
		span(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
			32'h0000_0001);
		pixel(8'hFF);
		pixel(8'h33);
		span(32'h0, 32'h0010_0000, 32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
		pixel(8'h00);
		span(32'h0000_8000, 32'h0008_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_8000,
			32'h0004_0001);
		load(REQ_TEX_LOAD, 16'h0040, 8'h07);
		repeat (3) pixel(8'h33);
		issue(blank_word(REQ_RSVD6));
		issue(blank_word(REQ_RSVD7));
		drain();
		set_modes(1, 0, 1, 4'd0, 16'hFFFF, 16'd1);
		span(32'h0, 32'h0020_0000, 32'h0, 32'h0002_0000, 32'h0, 32'h0004_0000);
		load(REQ_TEX_LOAD, 16'h0000, 8'h00);
		repeat (4) pixel(8'($urandom));
		drain();

		// random phases across register settings, extremes first
		set_modes(0, 1, 0, 4'd15, 16'hFFFF, 16'd65535);
		random_phase(190);
		drain();
		set_modes(1, 1, 1, 4'd0, 16'h0000, 16'd1);
		random_phase(190);
		drain();
		set_modes(1, 0, 0, 4'd3, 16'h00FF, 16'd65535);
		random_phase(100);
		// sender holds off until every result is back
		while (pending_words.size() != 0) @(posedge clk);
		hold_sender = 1;
		while (expected_results.size() != 0) @(posedge clk);
		hold_sender = 0;
		random_phase(90);
		drain();
		repeat (4) begin
			set_modes($urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
				4'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)));
			random_phase(190);
			drain();
		end
		set_modes(0, 0, 1, 4'd8, 16'hFFFF, 16'd256);
		quiet = 1;
		random_phase(180);
		drain();

		$display("covered %0d spans, %0d pixels, %0d loads, %0d reserved words", n_span,
			n_pixel, n_load, n_rsvd);
		$display("checked %0d result words over nine register settings, %0d errors",
			n_checked, errors);
		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

	// input driver
	always @(posedge clk) begin
		if (arst_n && (!in_valid || !in_stall)) begin
			if (idle_in > 0) begin
				idle_in <= idle_in - 1;
				in_valid <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				idle_in <= $urandom_range(0, 11);
				in_valid <= 1'b0;
			end else if (!hold_sender && pending_words.size() != 0) begin
				word_t w;
				w = pending_words.pop_front();
				in_valid <= 1'b1;
				req_type <= w.req;
				addr <= w.addr;
				data <= w.data;
				left_u <= w.lu;
				right_u <= w.ru;
				left_v <= w.lv;
				right_v <= w.rv;
				left_x <= w.lx;
				right_x <= w.rx;
				dest_pixel <= w.dest;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// result monitor and stall bursts
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				n_checked++;
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected word pixel=%h we=%b rej=%b cnt=%h", $time,
						pixel_out, write_enable, span_reject, span_pixels);
					errors++;
				end else begin
					res_t e;
					e = expected_results.pop_front();
					if (pixel_out !== e.pixel) begin
						$display("%0t: pixel_out expected %h actual %h", $time, e.pixel,
							pixel_out);
						errors++;
					end
					if (write_enable !== e.we) begin
						$display("%0t: write_enable expected %b actual %b", $time, e.we,
							write_enable);
						errors++;
					end
					if (span_reject !== e.reject) begin
						$display("%0t: span_reject expected %b actual %b", $time, e.reject,
							span_reject);
						errors++;
					end
					if (span_pixels !== e.pixels) begin
						$display("%0t: span_pixels expected %0d actual %0d", $time, e.pixels,
							span_pixels);
						errors++;
					end
				end
			end
			if (idle_out > 0) begin
				idle_out <= idle_out - 1;
				out_stall <= 1'b1;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				idle_out <= $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !arst_n)
			stale_cycles <= 0;
		else
			stale_cycles <= stale_cycles + 1;
		if (stale_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress, %0d results outstanding", $time,
				expected_results.size());
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
